[hw/rtl/i2cbs_pkg.sv]
// Package for the I2C master bit sequencer: payload structs, microcode word
// format, the microcode program table and the command entry table.
// No dependencies.
`default_nettype none

package i2cbs_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_CNT_W = $clog2(BYTE_BITS);
    localparam int PC_W      = 5;

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_STOP     = 3'd1,
        REQ_WRITE    = 3'd2,
        REQ_READ     = 3'd3,
        REQ_SEND_ACK = 3'd4,
        REQ_READ_ACK = 3'd5
    } req_t;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [BYTE_BITS-1:0] send_data;
        logic [BYTE_BITS-1:0] slave_data;
    } cmd_item_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 sample_phase;
        logic [BYTE_BITS-1:0] read_value;
        logic                 last_phase;
    } phase_item_t;

    typedef enum logic [1:0] {
        SCL_KEEP,
        SCL_LO,
        SCL_HI
    } scl_op_t;

    typedef enum logic [2:0] {
        SDA_KEEP,
        SDA_LO,
        SDA_HI,
        SDA_DATA,
        SDA_ACK
    } sda_op_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_BIT,
        CAP_ACK
    } cap_op_t;

    typedef struct packed {
        scl_op_t         scl_op;
        sda_op_t         sda_op;
        logic            sample;
        cap_op_t         cap;
        logic            shift_tx;
        logic            loop;
        logic            done;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic   step;
        logic   last;
        ucode_t word;
    } seq_ctl_t;

    localparam logic [PC_W-1:0] ENTRY_START    = PC_W'(0);
    localparam logic [PC_W-1:0] ENTRY_STOP     = PC_W'(4);
    localparam logic [PC_W-1:0] ENTRY_WRITE    = PC_W'(7);
    localparam logic [PC_W-1:0] ENTRY_READ     = PC_W'(10);
    localparam logic [PC_W-1:0] ENTRY_SEND_ACK = PC_W'(14);
    localparam logic [PC_W-1:0] ENTRY_READ_ACK = PC_W'(17);
    localparam logic [PC_W-1:0] WRITE_LOOP     = PC_W'(7);
    localparam logic [PC_W-1:0] READ_LOOP      = PC_W'(11);

    function automatic ucode_t uc(scl_op_t scl, sda_op_t sda, logic smp, cap_op_t cap,
                                  logic shf, logic lp, logic dn, logic [PC_W-1:0] tgt);
        ucode_t w;
        w.scl_op   = scl;
        w.sda_op   = sda;
        w.sample   = smp;
        w.cap      = cap;
        w.shift_tx = shf;
        w.loop     = lp;
        w.done     = dn;
        w.target   = tgt;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_W'(0):  w = uc(SCL_KEEP, SDA_HI,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(1):  w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(2):  w = uc(SCL_KEEP, SDA_LO,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(3):  w = uc(SCL_LO,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b1, '0);
            PC_W'(4):  w = uc(SCL_KEEP, SDA_LO,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(5):  w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(6):  w = uc(SCL_KEEP, SDA_HI,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b1, '0);
            PC_W'(7):  w = uc(SCL_KEEP, SDA_DATA, 1'b0, CAP_NONE, 1'b1, 1'b0, 1'b0, '0);
            PC_W'(8):  w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(9):  w = uc(SCL_LO,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b1, 1'b1,
                              WRITE_LOOP);
            PC_W'(10): w = uc(SCL_KEEP, SDA_HI,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(11): w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(12): w = uc(SCL_KEEP, SDA_KEEP, 1'b1, CAP_BIT,  1'b0, 1'b0, 1'b0, '0);
            PC_W'(13): w = uc(SCL_LO,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b1, 1'b1,
                              READ_LOOP);
            PC_W'(14): w = uc(SCL_KEEP, SDA_ACK,  1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(15): w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(16): w = uc(SCL_LO,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b1, '0);
            PC_W'(17): w = uc(SCL_KEEP, SDA_HI,   1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(18): w = uc(SCL_HI,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b0, '0);
            PC_W'(19): w = uc(SCL_KEEP, SDA_KEEP, 1'b1, CAP_ACK,  1'b0, 1'b0, 1'b0, '0);
            PC_W'(20): w = uc(SCL_LO,   SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b1, '0);
            default:   w = uc(SCL_KEEP, SDA_KEEP, 1'b0, CAP_NONE, 1'b0, 1'b0, 1'b1, '0);
        endcase
        return w;
    endfunction

    function automatic logic req_valid(logic [2:0] req);
        logic v;
        unique case (req)
            REQ_START, REQ_STOP, REQ_WRITE, REQ_READ, REQ_SEND_ACK, REQ_READ_ACK: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic [PC_W-1:0] entry_addr(logic [2:0] req);
        logic [PC_W-1:0] a;
        unique case (req)
            REQ_START:    a = ENTRY_START;
            REQ_STOP:     a = ENTRY_STOP;
            REQ_WRITE:    a = ENTRY_WRITE;
            REQ_READ:     a = ENTRY_READ;
            REQ_SEND_ACK: a = ENTRY_SEND_ACK;
            REQ_READ_ACK: a = ENTRY_READ_ACK;
            default:      a = ENTRY_START;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/i2cbs_sequencer.sv]
// Microcode sequencer: step counter, bit loop counter and program table lookup.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_sequencer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      launch,
    input  wire logic [2:0]                req_type,
    input  wire logic                      advance,
    output logic                           busy,
    output i2cbs_pkg::seq_ctl_t            ctl
);

    logic                               busy_reg, busy_next;
    logic [i2cbs_pkg::PC_W-1:0]         pc_reg, pc_next;
    logic [i2cbs_pkg::BIT_CNT_W-1:0]    bit_reg, bit_next;
    i2cbs_pkg::ucode_t                  word;
    logic                               bits_left;
    logic                               take_jump;
    logic                               step;

    assign word      = i2cbs_pkg::ucode_rom(pc_reg);
    assign bits_left = (bit_reg != i2cbs_pkg::BIT_CNT_W'(i2cbs_pkg::BYTE_BITS - 1));
    assign take_jump = word.loop && bits_left;
    assign step      = busy_reg && advance;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        bit_next  = bit_reg;
        if (launch)
        begin
            busy_next = 1'b1;
            pc_next   = i2cbs_pkg::entry_addr(req_type);
            bit_next  = '0;
        end
        else if (step)
        begin
            priority if (take_jump)
            begin
                pc_next  = word.target;
                bit_next = bit_reg + 1'b1;
            end
            else if (word.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            bit_reg  <= bit_next;
        end
    end

    assign busy      = busy_reg;
    assign ctl.step  = step;
    assign ctl.last  = word.done && !take_jump;
    assign ctl.word  = word;

endmodule

`default_nettype wire

[hw/rtl/i2cbs_datapath.sv]
// Line datapath: SCL and SDA state, byte shift registers, read assembly and
// the phase output register. Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                launch,
    input  wire logic [i2cbs_pkg::BYTE_BITS-1:0]     send_data,
    input  wire logic [i2cbs_pkg::BYTE_BITS-1:0]     slave_data,
    input  wire i2cbs_pkg::seq_ctl_t                 ctl,
    input  wire logic                                phase_ready,
    output logic                                     phase_valid,
    output i2cbs_pkg::phase_item_t                   phase
);

    localparam int BW = i2cbs_pkg::BYTE_BITS;

    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [BW-1:0]         tx_reg, tx_next;
    logic [BW-1:0]         rx_reg, rx_next;
    logic [BW-1:0]         rv_reg, rv_next;
    logic                  out_valid_reg, out_valid_next;
    i2cbs_pkg::phase_item_t out_reg, out_next;

    always_comb
    begin
        scl_next = scl_reg;
        unique case (ctl.word.scl_op)
            i2cbs_pkg::SCL_LO:   scl_next = 1'b0;
            i2cbs_pkg::SCL_HI:   scl_next = 1'b1;
            default:             scl_next = scl_reg;
        endcase

        sda_next = sda_reg;
        unique case (ctl.word.sda_op)
            i2cbs_pkg::SDA_LO:   sda_next = 1'b0;
            i2cbs_pkg::SDA_HI:   sda_next = 1'b1;
            i2cbs_pkg::SDA_DATA: sda_next = tx_reg[BW-1];
            i2cbs_pkg::SDA_ACK:  sda_next = tx_reg[0];
            default:             sda_next = sda_reg;
        endcase

        tx_next = ctl.word.shift_tx ? {tx_reg[BW-2:0], 1'b0} : tx_reg;

        rx_next = rx_reg;
        rv_next = rv_reg;
        unique case (ctl.word.cap)
            i2cbs_pkg::CAP_BIT:
            begin
                rv_next = {rv_reg[BW-2:0], rx_reg[BW-1]};
                rx_next = {rx_reg[BW-2:0], 1'b0};
            end
            i2cbs_pkg::CAP_ACK:  rv_next = {{(BW-1){1'b0}}, rx_reg[0]};
            default:
            begin
                rv_next = rv_reg;
            end
        endcase

        out_next.scl_level    = scl_next;
        out_next.sda_level    = sda_next;
        out_next.sample_phase = ctl.word.sample;
        out_next.read_value   = ctl.last ? rv_next : '0;
        out_next.last_phase   = ctl.last;

        out_valid_next = out_valid_reg;
        if (ctl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (phase_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctl.step)
            begin
                scl_reg <= scl_next;
                sda_reg <= sda_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            tx_reg <= send_data;
            rx_reg <= slave_data;
            rv_reg <= '0;
        end
        else if (ctl.step)
        begin
            tx_reg <= tx_next;
            rx_reg <= rx_next;
            rv_reg <= rv_next;
        end
        if (ctl.step)
        begin
            out_reg <= out_next;
        end
    end

    assign phase_valid = out_valid_reg;
    assign phase       = out_reg;

endmodule

`default_nettype wire

[hw/rtl/i2c_master_bit_sequencer_core.sv]
// I2C master bit sequencer top level: command channel in, line phase channel
// out. Depends on i2cbs_pkg, i2cbs_sequencer and i2cbs_datapath.
//
// The cmd channel takes one bus command per transfer (start, stop, write
// byte, read byte, send ack, read ack) together with the byte to send and
// the slave's SDA levels for the sample phases. The phase channel returns
// one transfer per line phase: SCL and SDA levels, a sample mark, and on the
// last phase of a command the byte or ack bit read.
// A command runs a short microcode program, one control word per phase, so
// a command of 3 to 25 phases passes through the program counter and then
// the phase output register and emits one phase each cycle while the phase
// channel does not stall; the next command is taken once the program has
// run its last phase. Codes 6 and 7 are taken and dropped without any phase.
// A stall on phase_ready holds the output register and freezes the program
// until the waiting phase is taken. cmd_ready is low while a program runs.
// Reset clears the program state, empties the output register and leaves
// both line levels released high.
`default_nettype none

module i2c_master_bit_sequencer_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cmd_valid,
    output logic                         cmd_ready,
    input  wire i2cbs_pkg::cmd_item_t    cmd,
    output logic                         phase_valid,
    input  wire logic                    phase_ready,
    output i2cbs_pkg::phase_item_t       phase
);

    logic                busy;
    logic                launch;
    logic                advance;
    i2cbs_pkg::seq_ctl_t ctl;

    assign cmd_ready = !busy;
    assign launch    = cmd_valid && cmd_ready && i2cbs_pkg::req_valid(cmd.req_type);
    assign advance   = !phase_valid || phase_ready;

    i2cbs_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (launch),
        .req_type (cmd.req_type),
        .advance  (advance),
        .busy     (busy),
        .ctl      (ctl)
    );

    i2cbs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .launch      (launch),
        .send_data   (cmd.send_data),
        .slave_data  (cmd.slave_data),
        .ctl         (ctl),
        .phase_ready (phase_ready),
        .phase_valid (phase_valid),
        .phase       (phase)
    );

    a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && i2cbs_pkg::req_valid(cmd.req_type) |=> !cmd_ready)
        else $error("command taken but program did not start");

    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid && !phase.last_phase |-> !cmd_ready)
        else $error("program ended before its last phase");

    a_read_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid && !phase.last_phase |-> phase.read_value == '0)
        else $error("read value shown before the last phase");

    a_sample_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid && phase.sample_phase |-> phase.sda_level && phase.scl_level)
        else $error("sample phase without released SDA and high SCL");

endmodule

`default_nettype wire

[test/i2cbs_phase_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the I2C master bit sequencer: watches the command and phase
// channels, works out the line phases of each command and compares them in order.
// Depends on i2cbs_pkg.
module i2cbs_phase_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic                   cmd_ready,
    input  i2cbs_pkg::cmd_item_t   cmd,
    input  logic                   phase_valid,
    input  logic                   phase_ready,
    input  i2cbs_pkg::phase_item_t phase,
    output int                     errors,
    output int                     pending
);

    logic                   scl_line;
    logic                   sda_line;
    i2cbs_pkg::phase_item_t expected_phases[$];

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t: phase mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic void add_phase(input logic smp);
        i2cbs_pkg::phase_item_t p;
        p = '0;
        p.scl_level = scl_line;
        p.sda_level = sda_line;
        p.sample_phase = smp;
        expected_phases.push_back(p);
    endfunction

    function automatic void set_scl(input logic v);
        scl_line = v;
        add_phase(1'b0);
    endfunction

    function automatic void set_sda(input logic v);
        sda_line = v;
        add_phase(1'b0);
    endfunction

    function automatic void predict_phases(input i2cbs_pkg::cmd_item_t c);
        logic [7:0]             captured;
        i2cbs_pkg::phase_item_t tail;
        captured = '0;
        case (c.req_type)
            i2cbs_pkg::REQ_START:
            begin
                set_sda(1'b1);
                set_scl(1'b1);
                set_sda(1'b0);
                set_scl(1'b0);
            end
            i2cbs_pkg::REQ_STOP:
            begin
                set_sda(1'b0);
                set_scl(1'b1);
                set_sda(1'b1);
            end
            i2cbs_pkg::REQ_WRITE:
            begin
                for (int i = i2cbs_pkg::BYTE_BITS - 1; i >= 0; i--)
                begin
                    set_sda(c.send_data[i]);
                    set_scl(1'b1);
                    set_scl(1'b0);
                end
            end
            i2cbs_pkg::REQ_READ:
            begin
                set_sda(1'b1);
                for (int i = i2cbs_pkg::BYTE_BITS - 1; i >= 0; i--)
                begin
                    set_scl(1'b1);
                    add_phase(1'b1);
                    captured[i] = c.slave_data[i];
                    set_scl(1'b0);
                end
            end
            i2cbs_pkg::REQ_SEND_ACK:
            begin
                set_sda(c.send_data[0]);
                set_scl(1'b1);
                set_scl(1'b0);
            end
            i2cbs_pkg::REQ_READ_ACK:
            begin
                set_sda(1'b1);
                set_scl(1'b1);
                add_phase(1'b1);
                captured = {7'b0, c.slave_data[0]};
                set_scl(1'b0);
            end
            default:
            begin
                return;
            end
        endcase
        tail = expected_phases.pop_back();
        tail.read_value = captured;
        tail.last_phase = 1'b1;
        expected_phases.push_back(tail);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        i2cbs_pkg::phase_item_t want;
        if (!rst_n)
        begin
            scl_line = 1'b1;
            sda_line = 1'b1;
            expected_phases.delete();
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_phases(cmd);
            end
            if (phase_valid && phase_ready)
            begin
                if (expected_phases.size() == 0)
                begin
                    report_mismatch("phase transfer with nothing expected");
                end
                else
                begin
                    want = expected_phases.pop_front();
                    check_field("scl_level", 8'(phase.scl_level), 8'(want.scl_level));
                    check_field("sda_level", 8'(phase.sda_level), 8'(want.sda_level));
                    check_field("sample_phase", 8'(phase.sample_phase),
                                8'(want.sample_phase));
                    check_field("read_value", phase.read_value, want.read_value);
                    check_field("last_phase", 8'(phase.last_phase), 8'(want.last_phase));
                end
            end
        end
        pending = expected_phases.size();
    end

endmodule

[test/i2c_master_bit_sequencer_core_test.sv]
`timescale 1ns / 1ps
// Testbench top for the I2C master bit sequencer: drives directed and random bus
// commands under varying idle and stall patterns and gives the verdict.
// Depends on i2cbs_pkg, i2c_master_bit_sequencer_core and i2cbs_phase_checker.
module i2c_master_bit_sequencer_core_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    i2cbs_pkg::cmd_item_t   cmd = '0;
    logic                   phase_ready = 1'b0;
    logic                   cmd_ready;
    logic                   phase_valid;
    i2cbs_pkg::phase_item_t phase;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int cmds_sent = 0;
    int errors;
    int pending;

    always #5 clk = ~clk;

    i2c_master_bit_sequencer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .phase_valid (phase_valid),
        .phase_ready (phase_ready),
        .phase       (phase)
    );

    i2cbs_phase_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .phase_valid (phase_valid),
        .phase_ready (phase_ready),
        .phase       (phase),
        .errors      (errors),
        .pending     (pending)
    );

    always @(posedge clk)
    begin
        phase_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] req, input logic [7:0] sd, input logic [7:0] sl);
        i2cbs_pkg::cmd_item_t c;
        int                   gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        c.req_type = req;
        c.send_data = sd;
        c.slave_data = sl;
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        if (req <= i2cbs_pkg::REQ_READ_ACK)
        begin
            cmds_sent++;
        end
    endtask

    task automatic run_transaction();
        int   nbytes;
        logic rd;
        nbytes = $urandom_range(1, 4);
        rd = 1'($urandom_range(1));
        send_cmd(i2cbs_pkg::REQ_START, 8'($urandom), 8'($urandom));
        send_cmd(i2cbs_pkg::REQ_WRITE, {7'($urandom), rd}, 8'($urandom));
        send_cmd(i2cbs_pkg::REQ_READ_ACK, 8'($urandom), 8'($urandom));
        for (int b = 0; b < nbytes; b++)
        begin
            if (rd)
            begin
                send_cmd(i2cbs_pkg::REQ_READ, 8'($urandom), 8'($urandom));
                send_cmd(i2cbs_pkg::REQ_SEND_ACK, {7'($urandom), b == nbytes - 1},
                         8'($urandom));
            end
            else
            begin
                send_cmd(i2cbs_pkg::REQ_WRITE, 8'($urandom), 8'($urandom));
                send_cmd(i2cbs_pkg::REQ_READ_ACK, 8'($urandom), 8'($urandom));
            end
        end
        if ($urandom_range(9) != 0)
        begin
            send_cmd(i2cbs_pkg::REQ_STOP, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_random(input int target);
        int first;
        first = cmds_sent;
        while (cmds_sent - first < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                run_transaction();
            end
            else
            begin
                send_cmd(3'($urandom_range(7)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(i2cbs_pkg::REQ_STOP, 8'hFF, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_START, 8'h00, 8'h00);
        send_cmd(i2cbs_pkg::REQ_WRITE, 8'h00, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_READ_ACK, 8'hFF, 8'hFE);
        send_cmd(i2cbs_pkg::REQ_WRITE, 8'hFF, 8'h00);
        send_cmd(i2cbs_pkg::REQ_READ_ACK, 8'h00, 8'h01);
        send_cmd(i2cbs_pkg::REQ_WRITE, 8'hA5, 8'h5A);
        send_cmd(i2cbs_pkg::REQ_WRITE, 8'h80, 8'h00);
        send_cmd(i2cbs_pkg::REQ_WRITE, 8'h01, 8'h00);
        send_cmd(3'd6, 8'hFF, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_START, 8'hFF, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_READ, 8'hFF, 8'h00);
        send_cmd(i2cbs_pkg::REQ_SEND_ACK, 8'hFE, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_READ, 8'h00, 8'hFF);
        send_cmd(i2cbs_pkg::REQ_SEND_ACK, 8'h01, 8'h00);
        send_cmd(i2cbs_pkg::REQ_READ, 8'h00, 8'h5A);
        send_cmd(i2cbs_pkg::REQ_SEND_ACK, 8'hFF, 8'h00);
        send_cmd(3'd7, 8'h00, 8'h00);
        send_cmd(i2cbs_pkg::REQ_STOP, 8'h00, 8'h00);
        send_cmd(i2cbs_pkg::REQ_STOP, 8'h00, 8'h00);
        send_cmd(i2cbs_pkg::REQ_READ_ACK, 8'h00, 8'hFF);

        run_random(48);
        idle_pct = 80;
        run_random(48);
        idle_pct = 0;
        stall_pct = 80;
        run_random(48);
        idle_pct = 11;
        stall_pct = 11;
        run_random(48);
        cmd_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
